// ===== src/ikarm_pkg.sv =====
// ----------------------------------------------------------------------------
// ikarm_pkg : shared widths, types and tables for the arm solver
// Word widths of every pipeline stage, the arctangent table of the CORDIC
// units, register indexes and the rounding helper for joint angles.
// ----------------------------------------------------------------------------
package ikarm_pkg;

   // angle format
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int CORDIC_STAGES   = 16;
   localparam int INT_FRAC        = 16;
   localparam int RSH             = INT_FRAC - ANGLE_FRAC_BITS;
   localparam int RND             = (RSH == 0) ? 0 : (1 << (RSH - 1));

   // word widths
   localparam int LEN_W   = 14;
   localparam int SQ_W    = 2 * LEN_W;
   localparam int H2_W    = SQ_W + 1;
   localparam int NUM_W   = H2_W + 2;
   localparam int MAG_W   = 30;
   localparam int RAD_W   = 2 * MAG_W;
   localparam int NX_W    = MAG_W + LEN_W + 1;
   localparam int HX_W    = H2_W + LEN_W;
   localparam int D2_W    = HX_W + 1;
   localparam int N2_W    = D2_W + 3;
   localparam int MN_W    = N2_W - 1;
   localparam int N2S_W   = MAG_W + 1;
   localparam int CY_W    = MAG_W + 2;
   localparam int CORD_W  = MAG_W + 4;
   localparam int ANG_W   = 26;
   localparam int T_W     = 27;
   localparam int ANGLE_W = 18;
   localparam int WRIST_W = 19;
   localparam int CSR_W   = 2;

   // pipeline shape
   localparam int ISQRT_STAGES = RAD_W / 2;
   localparam int NORM_STEPS   = 5;
   localparam int DEN_STEPS    = 4;
   localparam int CORDIC_LAT   = 1 + NORM_STEPS + CORDIC_STAGES;
   localparam int PIPE_LATENCY = 5 + ISQRT_STAGES + 3 + DEN_STEPS + 2
                                 + ISQRT_STAGES + CORDIC_LAT + 4;

   localparam logic [LEN_W-1:0] UPPER_RESET  = LEN_W'(1920);
   localparam logic [LEN_W-1:0] LOWER_RESET  = LEN_W'(1840);
   localparam logic [LEN_W-1:0] OFFSET_RESET = LEN_W'(400);

   localparam logic signed [T_W-1:0]     C180 = T_W'(180 << INT_FRAC);
   localparam logic signed [WRIST_W-1:0] C270 = WRIST_W'(270 << ANGLE_FRAC_BITS);

   typedef enum logic [CSR_W-1:0] {
      CSR_UPPER_LENGTH  = 2'd0,
      CSR_LOWER_LENGTH  = 2'd1,
      CSR_HEIGHT_OFFSET = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] num;
      logic signed [NX_W-1:0]  nx;
      logic [HX_W-1:0]         hx;
      logic [D2_W-1:0]         d2;
      logic [LEN_W-1:0]        reach;
      logic [LEN_W-1:0]        offset;
      logic                    err;
   } sb1_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] num;
      logic [MAG_W-1:0]        root;
      logic [LEN_W-1:0]        reach;
      logic [LEN_W-1:0]        offset;
      logic                    err;
   } mid_type;

   typedef struct packed {
      mid_type                 mid;
      logic signed [N2S_W-1:0] n2s;
   } sb2_type;

   // atan(2^-i) in degrees, 16 fractional bits
   function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
      case (idx)
         0:  return ANG_W'(2949120);
         1:  return ANG_W'(1740967);
         2:  return ANG_W'(919879);
         3:  return ANG_W'(466945);
         4:  return ANG_W'(234379);
         5:  return ANG_W'(117304);
         6:  return ANG_W'(58666);
         7:  return ANG_W'(29335);
         8:  return ANG_W'(14668);
         9:  return ANG_W'(7334);
         10: return ANG_W'(3667);
         11: return ANG_W'(1833);
         12: return ANG_W'(917);
         13: return ANG_W'(458);
         14: return ANG_W'(229);
         15: return ANG_W'(115);
         16: return ANG_W'(57);
         17: return ANG_W'(29);
         18: return ANG_W'(14);
         19: return ANG_W'(7);
         20: return ANG_W'(4);
         21: return ANG_W'(2);
         22: return ANG_W'(1);
         default: return '0;
      endcase
   endfunction

   // round half up to the output angle format
   function automatic logic signed [ANGLE_W-1:0] to_out(input logic signed [T_W-1:0] v);
      logic signed [T_W:0] biased;
      biased = (T_W+1)'(v) + (T_W+1)'(RND);
      return ANGLE_W'(biased >>> RSH);
   endfunction

endpackage

// ===== src/ikarm_isqrt.sv =====
// ----------------------------------------------------------------------------
// ikarm_isqrt : pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ikarm_isqrt (
   input  logic                          clock,
   input  logic [ikarm_pkg::RAD_W-1:0]   radicand,
   output logic [ikarm_pkg::MAG_W-1:0]   root
);
   import ikarm_pkg::*;

   localparam int REM_W = MAG_W + 2;

   logic [RAD_W-1:0] rad_ff  [ISQRT_STAGES];
   logic [RAD_W-1:0] rad_in  [ISQRT_STAGES];
   logic [REM_W-1:0] rem_ff  [ISQRT_STAGES];
   logic [REM_W-1:0] rem_in  [ISQRT_STAGES];
   logic [MAG_W-1:0] root_ff [ISQRT_STAGES];
   logic [MAG_W-1:0] root_in [ISQRT_STAGES];

   for (genvar g = 0; g < ISQRT_STAGES; g++) begin : g_stage
      logic [RAD_W-1:0] rad_p;
      logic [REM_W-1:0] rem_p;
      logic [MAG_W-1:0] root_p;
      logic [REM_W-1:0] rem_cat;
      logic [REM_W-1:0] trial;
      logic             take;

      if (g == 0) begin : g_first
         assign rad_p  = radicand;
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_rest
         assign rad_p  = rad_ff[g-1];
         assign rem_p  = rem_ff[g-1];
         assign root_p = root_ff[g-1];
      end

      // bring down the next pair of radicand bits
      assign rem_cat    = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
      assign trial      = {root_p, 2'b01};
      assign take       = rem_cat >= trial;
      assign rad_in[g]  = rad_p << 2;
      assign rem_in[g]  = take ? rem_cat - trial : rem_cat;
      assign root_in[g] = {root_p[MAG_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ISQRT_STAGES; i++) begin
         rad_ff[i]  <= rad_in[i];
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
      end
   end

   assign root = root_ff[ISQRT_STAGES-1];

endmodule

// ===== src/ikarm_cordic.sv =====
// ----------------------------------------------------------------------------
// ikarm_cordic : pipelined vectoring CORDIC, atan2(y, x) for x >= 0
// Scales the larger magnitude into [2^29, 2^30), then one rotation per stage.
// ----------------------------------------------------------------------------
module ikarm_cordic (
   input  logic                               clock,
   input  logic signed [ikarm_pkg::CY_W-1:0]  vec_y,
   input  logic [ikarm_pkg::MAG_W-1:0]        vec_x,
   output logic signed [ikarm_pkg::ANG_W-1:0] angle
);
   import ikarm_pkg::*;

   logic [CY_W-1:0]  ymag;
   logic             over;

   logic [MAG_W-1:0] my_ff  [NORM_STEPS+1];
   logic [MAG_W-1:0] my_in  [NORM_STEPS+1];
   logic [MAG_W-1:0] mx_ff  [NORM_STEPS+1];
   logic [MAG_W-1:0] mx_in  [NORM_STEPS+1];
   logic             neg_ff [NORM_STEPS+1];
   logic             neg_in [NORM_STEPS+1];

   logic signed [CORD_W-1:0] cx_ff [CORDIC_STAGES];
   logic signed [CORD_W-1:0] cx_in [CORDIC_STAGES];
   logic signed [CORD_W-1:0] cy_ff [CORDIC_STAGES];
   logic signed [CORD_W-1:0] cy_in [CORDIC_STAGES];
   logic signed [ANG_W-1:0]  z_ff  [CORDIC_STAGES];
   logic signed [ANG_W-1:0]  z_in  [CORDIC_STAGES];

   // range step: halve both when the larger reaches 2^30
   assign ymag      = vec_y[CY_W-1] ? -vec_y : vec_y;
   assign over      = ymag[CY_W-1:MAG_W] != '0;
   assign my_in[0]  = over ? ymag[MAG_W:1] : ymag[MAG_W-1:0];
   assign mx_in[0]  = over ? {1'b0, vec_x[MAG_W-1:1]} : vec_x;
   assign neg_in[0] = vec_y[CY_W-1];

   // left shifts of 16, 8, 4, 2, 1 while the larger stays below 2^30
   for (genvar g = 1; g <= NORM_STEPS; g++) begin : g_norm
      localparam int SH = 1 << (NORM_STEPS - g);
      logic fits;
      assign fits      = ((my_ff[g-1] | mx_ff[g-1]) >> (MAG_W - SH)) == '0;
      assign my_in[g]  = fits ? my_ff[g-1] << SH : my_ff[g-1];
      assign mx_in[g]  = fits ? mx_ff[g-1] << SH : mx_ff[g-1];
      assign neg_in[g] = neg_ff[g-1];
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_iter
      localparam logic signed [ANG_W-1:0] AT = atan_deg(g);
      logic signed [CORD_W-1:0] cx_p;
      logic signed [CORD_W-1:0] cy_p;
      logic signed [CORD_W-1:0] dx;
      logic signed [CORD_W-1:0] dy;
      logic signed [ANG_W-1:0]  z_p;

      if (g == 0) begin : g_first
         logic signed [CORD_W-1:0] my_ext;
         assign my_ext = {{(CORD_W-MAG_W){1'b0}}, my_ff[NORM_STEPS]};
         assign cx_p   = {{(CORD_W-MAG_W){1'b0}}, mx_ff[NORM_STEPS]};
         assign cy_p   = neg_ff[NORM_STEPS] ? -my_ext : my_ext;
         assign z_p    = '0;
      end else begin : g_rest
         assign cx_p = cx_ff[g-1];
         assign cy_p = cy_ff[g-1];
         assign z_p  = z_ff[g-1];
      end

      assign dx = cy_p >>> g;
      assign dy = cx_p >>> g;
      assign cx_in[g] = cy_p[CORD_W-1] ? cx_p - dx : cx_p + dx;
      assign cy_in[g] = cy_p[CORD_W-1] ? cy_p + dy : cy_p - dy;
      assign z_in[g]  = cy_p[CORD_W-1] ? z_p - AT : z_p + AT;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= NORM_STEPS; i++) begin
         my_ff[i]  <= my_in[i];
         mx_ff[i]  <= mx_in[i];
         neg_ff[i] <= neg_in[i];
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         cx_ff[i] <= cx_in[i];
         cy_ff[i] <= cy_in[i];
         z_ff[i]  <= z_in[i];
      end
   end

   assign angle = z_ff[CORDIC_STAGES-1];

endmodule

// ===== src/two_link_arm_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics : two-link planar arm solver
// Reach distance in, shoulder, elbow and wrist angles in degrees out.
// ----------------------------------------------------------------------------
// The solver is a fully pipelined datapath: it takes one reach word in every
// clock cycle (busy never rises) and marks each result with a one-cycle
// rsp_strobe. Most of the depth lies in the two 30-stage square-root
// pipelines and the 22-stage CORDIC units; results come out in input order
// and the receiver must take them in the strobe cycle, as there is no way to
// hold them off. Link lengths and height offset are written through the csr_
// port and must only change while no word is in flight. An unreachable
// target, a zero link or a zero hypotenuse returns zero angles with
// rsp_domain_error set.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [ikarm_pkg::LEN_W-1:0]            req_reach_distance,
   output logic                                   rsp_strobe,
   output logic signed [ikarm_pkg::ANGLE_W-1:0]   rsp_shoulder_angle,
   output logic signed [ikarm_pkg::ANGLE_W-1:0]   rsp_elbow_angle,
   output logic signed [ikarm_pkg::WRIST_W-1:0]   rsp_wrist_angle,
   output logic                                   rsp_domain_error,
   input  logic                                   csr_write_enable,
   input  logic [ikarm_pkg::CSR_W-1:0]            csr_index,
   input  logic [ikarm_pkg::LEN_W-1:0]            csr_write_data
);
   import ikarm_pkg::*;

   // configuration registers
   logic [LEN_W-1:0] upper_length_ff;
   logic [LEN_W-1:0] lower_length_ff;
   logic [LEN_W-1:0] height_offset_ff;

   // valid bit of every pipeline stage, output register last
   logic [PIPE_LATENCY-1:0] valid_ff;

   // stage 1: squares
   logic [LEN_W-1:0] a1_ff, b1_ff, x1_ff, l1_ff;
   logic [SQ_W-1:0]  aa1_ff, bb1_ff, xx1_ff, ll1_ff;
   // stage 2: hypotenuse squared
   logic [H2_W-1:0]         h2_2_ff;
   logic signed [H2_W-1:0]  dif2_ff;
   logic [SQ_W-1:0]         aa2_ff;
   logic [LEN_W-1:0]        b2_ff, x2_ff, l2_ff;
   logic                    err2_ff;
   // stage 3: shoulder numerator
   logic signed [NUM_W-1:0] num3_ff;
   logic [H2_W-1:0]         h2_3_ff;
   logic [SQ_W+1:0]         a4_3_ff;
   logic [LEN_W-1:0]        b3_ff, x3_ff, l3_ff;
   logic                    err3_ff;
   // stage 4: products
   logic signed [NUM_W-1:0] nabs;
   logic [RAD_W-1:0]        nsq_in, den_in;
   logic signed [NX_W-1:0]  nx_in;
   logic [HX_W-1:0]         hx_in;
   logic [HX_W-1:0]         hb_in;
   logic [RAD_W-1:0]        nsq4_ff, den4_ff;
   logic signed [NX_W-1:0]  nx4_ff;
   logic [HX_W-1:0]         hx4_ff;
   logic [D2_W-1:0]         d2_4_ff;
   logic signed [NUM_W-1:0] num4_ff;
   logic [LEN_W-1:0]        x4_ff, l4_ff;
   logic                    err4_ff;
   // stage 5: shoulder radicand
   logic [RAD_W-1:0]        rad5_ff;
   sb1_type                 sb5_ff;
   sb1_type                 sb1_ff [ISQRT_STAGES];
   logic [MAG_W-1:0]        root1;
   // stages 6 to 8: elbow numerator and range test
   logic [D2_W-1:0]         rl_in;
   logic [D2_W-1:0]         rl6_ff;
   logic signed [NX_W-1:0]  nx6_ff;
   logic [HX_W-1:0]         hx6_ff;
   logic [D2_W-1:0]         d2_6_ff, d2_7_ff, d8_ff;
   mid_type                 mid6_ff, mid7_ff, mid8_ff;
   mid_type                 mid8_in;
   logic signed [N2_W-1:0]  n2_7_ff;
   logic signed [N2_W-1:0]  n2abs;
   logic [MN_W-1:0]         mn8_ff;
   logic                    neg8_ff;
   // elbow denominator scaling
   logic [MN_W-1:0]         dk_mn_ff  [DEN_STEPS];
   logic [MN_W-1:0]         dk_mn_in  [DEN_STEPS];
   logic [D2_W-1:0]         dk_d_ff   [DEN_STEPS];
   logic [D2_W-1:0]         dk_d_in   [DEN_STEPS];
   logic                    dk_neg_ff [DEN_STEPS];
   logic                    dk_neg_in [DEN_STEPS];
   mid_type                 dk_mid_ff [DEN_STEPS];
   mid_type                 dk_mid_in [DEN_STEPS];
   // stages 13 and 14: elbow radicand
   logic [MAG_W-1:0]        mn30, d30;
   logic [RAD_W-1:0]        dd_in, nn_in;
   logic [RAD_W-1:0]        dd13_ff, nn13_ff, rad14_ff;
   logic signed [N2S_W-1:0] n2s13_ff;
   mid_type                 mid13_ff;
   sb2_type                 sb14_ff;
   sb2_type                 sb2_ff [ISQRT_STAGES];
   logic [MAG_W-1:0]        root2;
   // arctangents
   logic signed [CY_W-1:0]  ya, yp, yb;
   logic signed [ANG_W-1:0] ang_a, ang_p, ang_b;
   logic                    errc_ff [CORDIC_LAT];
   // angle assembly
   logic signed [T_W-1:0]     t1a_ff, t2b_ff;
   logic signed [ANG_W-1:0]   angb_a_ff;
   logic signed [ANGLE_W-1:0] sb_ff, sc_ff, ec_ff;
   logic                      erra_ff, errb_ff, errc_out_ff;
   logic signed [WRIST_W-1:0] wrist_in;

   // the pipeline takes a word in every cycle
   assign busy = 1'b0;

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_length_ff  <= UPPER_RESET;
         lower_length_ff  <= LOWER_RESET;
         height_offset_ff <= OFFSET_RESET;
         valid_ff         <= '0;
      end else begin
         valid_ff <= {valid_ff[PIPE_LATENCY-2:0], start};
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_UPPER_LENGTH:  upper_length_ff  <= csr_write_data;
               CSR_LOWER_LENGTH:  lower_length_ff  <= csr_write_data;
               CSR_HEIGHT_OFFSET: height_offset_ff <= csr_write_data;
               default: ; // drop writes to unused indexes
            endcase
         end
      end
   end

   assign rsp_strobe = valid_ff[PIPE_LATENCY-1];

   // --------------------------------------------------------------- datapath
   assign nabs   = num3_ff[NUM_W-1] ? -num3_ff : num3_ff;
   assign nsq_in = nabs[MAG_W-1:0] * nabs[MAG_W-1:0];
   assign den_in = a4_3_ff * h2_3_ff;
   assign nx_in  = num3_ff * $signed({1'b0, x3_ff});
   assign hx_in  = h2_3_ff * x3_ff;
   assign hb_in  = h2_3_ff * b3_ff;
   assign rl_in  = sb1_ff[ISQRT_STAGES-1].reach * root1;
   assign n2abs  = n2_7_ff[N2_W-1] ? -n2_7_ff : n2_7_ff;

   // stage 8 side data: flag an elbow asin argument outside [-1,1]
   always_comb begin
      mid8_in     = mid7_ff;
      mid8_in.err = mid7_ff.err || (n2abs[MN_W-1:0] > {2'b0, d2_7_ff});
   end

   // elbow scaling: shift by 8, 4, 2, 1 while the shifted denominator stays at 2^29 or more
   for (genvar g = 0; g < DEN_STEPS; g++) begin : g_den
      localparam int SH = 8 >> g;
      logic [MN_W-1:0] mn_p;
      logic [D2_W-1:0] d_p;
      logic            big;
      if (g == 0) begin : g_first
         assign mn_p         = mn8_ff;
         assign d_p          = d8_ff;
         assign dk_neg_in[g] = neg8_ff;
         assign dk_mid_in[g] = mid8_ff;
      end else begin : g_rest
         assign mn_p         = dk_mn_ff[g-1];
         assign d_p          = dk_d_ff[g-1];
         assign dk_neg_in[g] = dk_neg_ff[g-1];
         assign dk_mid_in[g] = dk_mid_ff[g-1];
      end
      assign big         = (d_p >> (MAG_W - 1 + SH)) != '0;
      assign dk_mn_in[g] = big ? mn_p >> SH : mn_p;
      assign dk_d_in[g]  = big ? d_p >> SH : d_p;
   end

   assign mn30  = dk_mn_ff[DEN_STEPS-1][MAG_W-1:0];
   assign d30   = dk_d_ff[DEN_STEPS-1][MAG_W-1:0];
   assign dd_in = d30 * d30;
   assign nn_in = mn30 * mn30;

   always_ff @(posedge clock) begin
      // stage 1
      a1_ff  <= upper_length_ff;
      b1_ff  <= lower_length_ff;
      x1_ff  <= height_offset_ff;
      l1_ff  <= req_reach_distance;
      aa1_ff <= upper_length_ff * upper_length_ff;
      bb1_ff <= lower_length_ff * lower_length_ff;
      xx1_ff <= height_offset_ff * height_offset_ff;
      ll1_ff <= req_reach_distance * req_reach_distance;
      // stage 2
      h2_2_ff <= {1'b0, xx1_ff} + {1'b0, ll1_ff};
      dif2_ff <= $signed({1'b0, aa1_ff}) - $signed({1'b0, bb1_ff});
      aa2_ff  <= aa1_ff;
      b2_ff   <= b1_ff;
      x2_ff   <= x1_ff;
      l2_ff   <= l1_ff;
      err2_ff <= (xx1_ff == '0 && ll1_ff == '0) || a1_ff == '0 || b1_ff == '0;
      // stage 3
      num3_ff <= $signed({2'b0, h2_2_ff}) + NUM_W'(dif2_ff);
      h2_3_ff <= h2_2_ff;
      a4_3_ff <= {aa2_ff, 2'b00};
      b3_ff   <= b2_ff;
      x3_ff   <= x2_ff;
      l3_ff   <= l2_ff;
      err3_ff <= err2_ff;
      // stage 4
      nsq4_ff <= nsq_in;
      den4_ff <= den_in;
      nx4_ff  <= nx_in;
      hx4_ff  <= hx_in;
      d2_4_ff <= {hb_in, 1'b0};
      num4_ff <= num3_ff;
      x4_ff   <= x3_ff;
      l4_ff   <= l3_ff;
      err4_ff <= err3_ff;
      // stage 5: shoulder asin range test
      rad5_ff       <= den4_ff - nsq4_ff;
      sb5_ff.num    <= num4_ff;
      sb5_ff.nx     <= nx4_ff;
      sb5_ff.hx     <= hx4_ff;
      sb5_ff.d2     <= d2_4_ff;
      sb5_ff.reach  <= l4_ff;
      sb5_ff.offset <= x4_ff;
      sb5_ff.err    <= err4_ff || (nsq4_ff > den4_ff);
      // hold side data alongside the first root
      sb1_ff[0] <= sb5_ff;
      for (int i = 1; i < ISQRT_STAGES; i++) begin
         sb1_ff[i] <= sb1_ff[i-1];
      end
      // stage 6
      rl6_ff         <= rl_in;
      nx6_ff         <= sb1_ff[ISQRT_STAGES-1].nx;
      hx6_ff         <= sb1_ff[ISQRT_STAGES-1].hx;
      d2_6_ff        <= sb1_ff[ISQRT_STAGES-1].d2;
      mid6_ff.num    <= sb1_ff[ISQRT_STAGES-1].num;
      mid6_ff.root   <= root1;
      mid6_ff.reach  <= sb1_ff[ISQRT_STAGES-1].reach;
      mid6_ff.offset <= sb1_ff[ISQRT_STAGES-1].offset;
      mid6_ff.err    <= sb1_ff[ISQRT_STAGES-1].err;
      // stage 7: elbow numerator
      n2_7_ff <= N2_W'(nx6_ff) + $signed({3'b0, rl6_ff})
                 - $signed({3'b0, hx6_ff, 1'b0});
      d2_7_ff <= d2_6_ff;
      mid7_ff <= mid6_ff;
      // stage 8: elbow asin range test
      mn8_ff  <= n2abs[MN_W-1:0];
      neg8_ff <= n2_7_ff[N2_W-1];
      d8_ff   <= d2_7_ff;
      mid8_ff <= mid8_in;
      // denominator scaling
      for (int i = 0; i < DEN_STEPS; i++) begin
         dk_mn_ff[i]  <= dk_mn_in[i];
         dk_d_ff[i]   <= dk_d_in[i];
         dk_neg_ff[i] <= dk_neg_in[i];
         dk_mid_ff[i] <= dk_mid_in[i];
      end
      // stage 13
      n2s13_ff <= dk_neg_ff[DEN_STEPS-1] ? -$signed({1'b0, mn30}) : $signed({1'b0, mn30});
      dd13_ff  <= dd_in;
      nn13_ff  <= nn_in;
      mid13_ff <= dk_mid_ff[DEN_STEPS-1];
      // stage 14: elbow radicand
      rad14_ff    <= dd13_ff - nn13_ff;
      sb14_ff.mid <= mid13_ff;
      sb14_ff.n2s <= n2s13_ff;
      sb2_ff[0]   <= sb14_ff;
      for (int i = 1; i < ISQRT_STAGES; i++) begin
         sb2_ff[i] <= sb2_ff[i-1];
      end
      // carry the error flag past the CORDIC units
      errc_ff[0] <= sb2_ff[ISQRT_STAGES-1].mid.err;
      for (int i = 1; i < CORDIC_LAT; i++) begin
         errc_ff[i] <= errc_ff[i-1];
      end
      // shoulder angle, full precision
      t1a_ff    <= C180 - T_W'(ang_a) - T_W'(ang_p);
      angb_a_ff <= ang_b;
      erra_ff   <= errc_ff[CORDIC_LAT-1];
      // elbow angle, full precision; round the shoulder
      t2b_ff  <= C180 - T_W'(angb_a_ff) - t1a_ff;
      sb_ff   <= to_out(t1a_ff);
      errb_ff <= erra_ff;
      // round the elbow
      ec_ff       <= to_out(t2b_ff);
      sc_ff       <= sb_ff;
      errc_out_ff <= errb_ff;
      // output register: zero the angles of an unreachable target, a zero link or a zero hypotenuse
      rsp_shoulder_angle <= errc_out_ff ? '0 : sc_ff;
      rsp_elbow_angle    <= errc_out_ff ? '0 : ec_ff;
      rsp_wrist_angle    <= errc_out_ff ? '0 : wrist_in;
      rsp_domain_error   <= errc_out_ff;
   end

   // wrist from the rounded joints, so the three sum to 270 degrees
   assign wrist_in = C270 - WRIST_W'(sc_ff) - WRIST_W'(ec_ff);

   // ---------------------------------------------------------- square roots
   ikarm_isqrt u_isqrt_shoulder (
      .clock    (clock),
      .radicand (rad5_ff),
      .root     (root1)
   );

   ikarm_isqrt u_isqrt_elbow (
      .clock    (clock),
      .radicand (rad14_ff),
      .root     (root2)
   );

   // ------------------------------------------------------------ arctangents
   assign ya = CY_W'(sb2_ff[ISQRT_STAGES-1].mid.num);
   assign yp = $signed({{(CY_W-LEN_W){1'b0}}, sb2_ff[ISQRT_STAGES-1].mid.reach});
   assign yb = CY_W'(sb2_ff[ISQRT_STAGES-1].n2s);

   ikarm_cordic u_cordic_asin_shoulder (
      .clock (clock),
      .vec_y (ya),
      .vec_x (sb2_ff[ISQRT_STAGES-1].mid.root),
      .angle (ang_a)
   );

   ikarm_cordic u_cordic_acos_shoulder (
      .clock (clock),
      .vec_y (yp),
      .vec_x ({{(MAG_W-LEN_W){1'b0}}, sb2_ff[ISQRT_STAGES-1].mid.offset}),
      .angle (ang_p)
   );

   ikarm_cordic u_cordic_asin_elbow (
      .clock (clock),
      .vec_y (yb),
      .vec_x (root2),
      .angle (ang_b)
   );

   // ------------------------------------------------------------- assertions
   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##PIPE_LATENCY rsp_strobe)
      else $error("accepted word did not appear after the pipeline latency");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_domain_error |->
         rsp_shoulder_angle == '0 && rsp_elbow_angle == '0 && rsp_wrist_angle == '0)
      else $error("domain error with non-zero angles");

   a_angle_sum : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_domain_error |->
         WRIST_W'(WRIST_W'(rsp_shoulder_angle) + WRIST_W'(rsp_elbow_angle)
                  + rsp_wrist_angle) == C270)
      else $error("joint angles do not sum to 270 degrees");

endmodule
